// ===== rtl/fpp_pkg.sv =====
// Shared types, sizes, command codes and the 1/3-sample interpolation table
// for the fractional pitch predictor. No dependencies.
package fpp_pkg;

    localparam int RING_DEPTH   = 256;
    localparam int MAX_SUBFRAME = 64;
    localparam int TAP_COUNT    = 32;

    localparam int AW        = $clog2(RING_DEPTH);
    localparam int IW        = $clog2(MAX_SUBFRAME);
    localparam int LW        = $clog2(MAX_SUBFRAME + 1);
    localparam int KW        = $clog2(TAP_COUNT);
    localparam int HALF_TAPS = TAP_COUNT / 2;

    localparam logic [6:0] SUBFRAME_RESET = 7'd60;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_PREDICT = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;

    localparam logic [1:0] FRAC_ZERO    = 2'b00;
    localparam logic [1:0] FRAC_PLUS    = 2'b01;
    localparam logic [1:0] FRAC_INVALID = 2'b10;

    // +1/3 interpolation taps; the -1/3 filter reads them reversed
    localparam logic signed [15:0] THIRD_TAPS [TAP_COUNT] = '{
        -16'sd47,    16'sd59,   -16'sd84,   16'sd125,  -16'sd183,
         16'sd263,  -16'sd366,   16'sd500, -16'sd672,   16'sd893,
        -16'sd1185,  16'sd1587, -16'sd2182, 16'sd3179, -16'sd5287,
         16'sd13496, 16'sd27072, -16'sd6669, 16'sd3688, -16'sd2452,
         16'sd1758, -16'sd1304,  16'sd981, -16'sd739,   16'sd553,
        -16'sd407,   16'sd294,  -16'sd207,  16'sd142,  -16'sd96,
         16'sd66,   -16'sd49
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY_RD,
        S_COPY_WB,
        S_TAP,
        S_DRAIN1,
        S_DRAIN2,
        S_ROUND
    } t_state;

    function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return s[31:0];
    endfunction

    // double with saturation, add one half LSB of the result, keep the high half
    function automatic logic signed [15:0] round_hi(input logic signed [31:0] acc);
        logic signed [31:0] dbl;
        logic signed [31:0] rnd;
        dbl = sat_add32(acc, acc);
        rnd = sat_add32(dbl, 32'sd32768);
        return rnd[31:16];
    endfunction

endpackage

// ===== rtl/fractional_pitch_predictor_core.sv =====
// Fractional pitch predictor top level: excitation ring memory, command
// sequencer and saturating tap MAC. Depends on fpp_pkg.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+----------------------------------
//  request   | in        | i_start, o_busy              | i_command i_position i_value
//            |           |                              | i_lag i_fraction
//  result    | out       | o_strobe (one cycle, no stall) | o_sample o_index o_last
//  config    | in        | i_cfg_valid, o_cfg_ready     | i_cfg_data (subframe length)
//
// Write and advance requests complete without leaving idle. A predict
// request copies each sample straight through with fraction 0, or with
// fraction +1/-1 makes 32 tap reads through the single ring read port, then
// passes product, accumulate and round/write-back stages. Samples go out one
// at a time, each written back before the next sample's reads begin.
// Synchronous active-low reset clears the base pointer and sets the subframe
// length to 60; ring contents are undefined until written.
// The result side cannot stall; o_busy holds off requests while predicting.
module fractional_pitch_predictor_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  logic [1:0]        i_command,
    input  logic signed [8:0] i_position,
    input  logic signed [15:0] i_value,
    input  logic [7:0]        i_lag,
    input  logic signed [1:0] i_fraction,
    output logic              o_strobe,
    output logic signed [15:0] o_sample,
    output logic [5:0]        o_index,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_data
);

    localparam int AW = fpp_pkg::AW;
    localparam int IW = fpp_pkg::IW;
    localparam int LW = fpp_pkg::LW;
    localparam int KW = fpp_pkg::KW;

    // Excitation ring: one write port, one registered read port
    logic signed [15:0] r_ring [fpp_pkg::RING_DEPTH];
    logic signed [15:0] r_rd_data;

    fpp_pkg::t_state r_state, n_state;

    logic [AW-1:0]      r_base, n_base;
    logic [6:0]         r_cfg_len;
    logic [LW-1:0]      r_len, n_len;
    logic [7:0]         r_lag, n_lag;
    logic               r_plus, n_plus;
    logic [IW-1:0]      r_i, n_i;
    logic [KW-1:0]      r_k, n_k;
    logic signed [15:0] r_coef, n_coef;
    logic               r_rd_vld, n_rd_vld;
    logic signed [31:0] r_prod;
    logic               r_prod_vld;
    logic signed [31:0] r_acc;
    logic               acc_clr;
    logic               r_strobe, n_strobe;
    logic signed [15:0] r_sample, n_sample;
    logic [IW-1:0]      r_index;
    logic               r_last, n_last;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic signed [15:0] mem_wd;
    logic               mem_re;
    logic [AW-1:0]      mem_ra;

    logic [LW-1:0]      len_eff;
    logic [AW-1:0]      centre;
    logic [AW-1:0]      tap_addr;
    logic               is_last;
    logic               accept;

    assign accept      = i_start && (r_state == fpp_pkg::S_IDLE);
    assign o_busy      = (r_state != fpp_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == fpp_pkg::S_IDLE);

    // Clamp the programmed length to the largest subframe
    always_comb begin
        if (int'(r_cfg_len) > fpp_pkg::MAX_SUBFRAME) begin
            len_eff = LW'(fpp_pkg::MAX_SUBFRAME);
        end else begin
            len_eff = LW'(r_cfg_len);
        end
    end

    // Ring address of the sample lag positions back from the current one
    assign centre   = r_base + AW'(r_i) - AW'(r_lag);
    assign tap_addr = centre + AW'(r_k)
                    - (r_plus ? AW'(fpp_pkg::HALF_TAPS) : AW'(fpp_pkg::HALF_TAPS - 1));
    assign is_last  = ((LW'(r_i) + LW'(1)) == r_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_len    = r_len;
        n_lag    = r_lag;
        n_plus   = r_plus;
        n_i      = r_i;
        n_k      = r_k;
        n_coef   = r_coef;
        n_rd_vld = 1'b0;
        acc_clr  = 1'b0;
        n_strobe = 1'b0;
        n_sample = r_sample;
        n_last   = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = r_base + AW'(r_i);
        mem_wd   = r_rd_data;
        mem_re   = 1'b0;
        mem_ra   = centre;

        unique case (r_state)
            fpp_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_command)
                        fpp_pkg::CMD_WRITE: begin
                            // store one history sample relative to the base
                            mem_we = 1'b1;
                            mem_wa = r_base + AW'(i_position);
                            mem_wd = i_value;
                        end
                        fpp_pkg::CMD_ADVANCE: begin
                            n_base = r_base + AW'(len_eff);
                        end
                        fpp_pkg::CMD_PREDICT: begin
                            n_len  = len_eff;
                            n_lag  = i_lag;
                            n_plus = (i_fraction == fpp_pkg::FRAC_PLUS);
                            n_i    = '0;
                            n_k    = '0;
                            if ((i_fraction != fpp_pkg::FRAC_INVALID) && (len_eff != '0)) begin
                                if (i_fraction == fpp_pkg::FRAC_ZERO) begin
                                    n_state = fpp_pkg::S_COPY_RD;
                                end else begin
                                    acc_clr = 1'b1;
                                    n_state = fpp_pkg::S_TAP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fpp_pkg::S_COPY_RD: begin
                mem_re  = 1'b1;
                n_state = fpp_pkg::S_COPY_WB;
            end
            fpp_pkg::S_COPY_WB: begin
                mem_we   = 1'b1;
                n_strobe = 1'b1;
                n_sample = r_rd_data;
                n_last   = is_last;
                n_i      = r_i + IW'(1);
                n_state  = is_last ? fpp_pkg::S_IDLE : fpp_pkg::S_COPY_RD;
            end
            fpp_pkg::S_TAP: begin
                mem_re   = 1'b1;
                mem_ra   = tap_addr;
                n_rd_vld = 1'b1;
                n_coef   = r_plus ? fpp_pkg::THIRD_TAPS[r_k]
                                  : fpp_pkg::THIRD_TAPS[KW'(fpp_pkg::TAP_COUNT - 1) - r_k];
                n_k      = r_k + KW'(1);
                if (r_k == KW'(fpp_pkg::TAP_COUNT - 1)) begin
                    n_state = fpp_pkg::S_DRAIN1;
                end
            end
            fpp_pkg::S_DRAIN1: begin
                n_state = fpp_pkg::S_DRAIN2;
            end
            fpp_pkg::S_DRAIN2: begin
                n_state = fpp_pkg::S_ROUND;
            end
            fpp_pkg::S_ROUND: begin
                // round, write back into the ring and emit in the same cycle
                n_sample = fpp_pkg::round_hi(r_acc);
                mem_we   = 1'b1;
                mem_wd   = n_sample;
                n_strobe = 1'b1;
                n_last   = is_last;
                n_i      = r_i + IW'(1);
                n_k      = '0;
                if (is_last) begin
                    n_state = fpp_pkg::S_IDLE;
                end else begin
                    acc_clr = 1'b1;
                    n_state = fpp_pkg::S_TAP;
                end
            end
            default: begin
                n_state = fpp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_ring[mem_ra];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_cfg_len  <= fpp_pkg::SUBFRAME_RESET;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_strobe   <= 1'b0;
            r_last     <= 1'b0;
        end else begin
            r_base     <= n_base;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_len <= i_cfg_data;
            end
            r_rd_vld   <= n_rd_vld;
            r_prod_vld <= r_rd_vld;
            r_strobe   <= n_strobe;
            r_last     <= n_last;
        end
    end

    // Payload and datapath registers
    always_ff @(posedge i_clk) begin
        r_len    <= n_len;
        r_lag    <= n_lag;
        r_plus   <= n_plus;
        r_i      <= n_i;
        r_k      <= n_k;
        r_coef   <= n_coef;
        r_prod   <= r_rd_data * r_coef;
        r_sample <= n_sample;
        if (n_strobe) begin
            r_index <= r_i;
        end
        if (acc_clr) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= fpp_pkg::sat_add32(r_acc, r_prod);
        end
    end

    assign o_strobe = r_strobe;
    assign o_sample = r_sample;
    assign o_index  = 6'(r_index);
    assign o_last   = r_last;

`ifndef SYNTHESIS
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(r_state) == fpp_pkg::S_COPY_WB || $past(r_state) == fpp_pkg::S_ROUND))
        else $error("result strobe without a write-back stage");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> o_busy)
        else $error("sequencer stopped before the final sample");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !o_busy)
        else $error("sequencer still running after the final sample");

    a_round_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpp_pkg::S_ROUND) |-> ($past(r_state) == fpp_pkg::S_DRAIN2))
        else $error("rounding entered before the MAC pipeline drained");

    a_mac_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fpp_pkg::S_COPY_RD || r_state == fpp_pkg::S_COPY_WB) |-> !r_prod_vld)
        else $error("tap product pending during a plain copy");
`endif

endmodule
